// ===== design/rpa_pkg.sv =====
package rpa_pkg;

    // operation codes
    localparam logic [3:0] OP_LOAD  = 4'd0;
    localparam logic [3:0] OP_SETLO = 4'd1;
    localparam logic [3:0] OP_SETHI = 4'd2;
    localparam logic [3:0] OP_INCW  = 4'd3;
    localparam logic [3:0] OP_DECW  = 4'd4;
    localparam logic [3:0] OP_INCLO = 4'd5;
    localparam logic [3:0] OP_INCHI = 4'd6;
    localparam logic [3:0] OP_DECLO = 4'd7;
    localparam logic [3:0] OP_DECHI = 4'd8;
    localparam logic [3:0] OP_ADD   = 4'd9;
    localparam logic [3:0] OP_ADC   = 4'd10;
    localparam logic [3:0] OP_SBC   = 4'd11;
    localparam logic [3:0] OP_SWAP  = 4'd12;

    // flag bit positions
    localparam int unsigned FLAG_C  = 0;
    localparam int unsigned FLAG_N  = 1;
    localparam int unsigned FLAG_PV = 2;
    localparam int unsigned FLAG_B3 = 3;
    localparam int unsigned FLAG_H  = 4;
    localparam int unsigned FLAG_B5 = 5;
    localparam int unsigned FLAG_Z  = 6;
    localparam int unsigned FLAG_S  = 7;

    localparam logic [7:0] BYTE_INC_OVF = 8'h80;
    localparam logic [7:0] BYTE_DEC_OVF = 8'h7F;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] flags;
    } byte_step_t;

    // 8-bit increment or decrement of one byte with its flag update
    function automatic byte_step_t byte_step(input logic [7:0] b, input logic dec,
                                             input logic [7:0] f);
        byte_step_t s;
        logic [7:0] r;
        r = dec ? (b - 8'd1) : (b + 8'd1);
        s.flags = f;
        s.value = r;
        s.flags[FLAG_H]  = dec ? (r[3:0] == 4'hF) : (r[3:0] == 4'h0);
        s.flags[FLAG_PV] = dec ? (r == BYTE_DEC_OVF) : (r == BYTE_INC_OVF);
        s.flags[FLAG_N]  = dec;
        s.flags[FLAG_Z]  = (r == 8'd0);
        s.flags[FLAG_S]  = r[7];
        return s;
    endfunction

endpackage

// ===== design/register_pair_arith_with_flags_core.sv =====
// 16-bit register pair with shadow copy and flag arithmetic
// path: the input reg loads a word on accept and the result reg loads it when the input stage
// advances, which a result word waiting on out_stall can hold off
// throughput: one word per cycle while out_stall stays low; the state update is one 17-bit add/subtract per word
// reset (rst_n low, async): current and shadow words clear to zero, both stages empty
// while a result word waits on out_stall the input reg can still take one more word
module register_pair_arith_with_flags_core
    import rpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic [15:0] data_word,
    input  logic [7:0]  flags_in,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] reg_value,
    output logic [7:0]  flags_out
);

    // input stage
    logic        s1_valid_reg;
    logic [3:0]  s1_op_reg;
    logic [15:0] s1_data_reg;
    logic [7:0]  s1_flags_reg;

    // architectural state
    logic [15:0] cur_reg, cur_next;
    logic [15:0] shadow_reg, shadow_next;

    // result stage
    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic [7:0]  out_flags_reg;
    logic [7:0]  flags_next;

    logic        s1_adv;
    logic        cin;
    logic [16:0] full;
    logic [16:0] cb;
    byte_step_t  bs;
    logic [7:0]  bs_src;

    // the input stage moves on whenever the result register is empty or being read
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;

    assign out_valid = out_valid_reg;
    assign reg_value = out_value_reg;
    assign flags_out = out_flags_reg;

    // one shared byte inc/dec unit serves all four byte opcodes
    always_comb
    begin
        bs_src = ((s1_op_reg == OP_INCHI) || (s1_op_reg == OP_DECHI)) ?
                 cur_reg[15:8] : cur_reg[7:0];
        bs = byte_step(bs_src, (s1_op_reg == OP_DECLO) || (s1_op_reg == OP_DECHI),
                       s1_flags_reg);
    end

    // one 17-bit adder serves add, adc and sbc
    always_comb
    begin
        cin  = ((s1_op_reg == OP_ADC) || (s1_op_reg == OP_SBC)) && s1_flags_reg[FLAG_C];
        if (s1_op_reg == OP_SBC)
            full = {1'b0, cur_reg} - {1'b0, s1_data_reg} - {16'd0, cin};
        else
            full = {1'b0, cur_reg} + {1'b0, s1_data_reg} + {16'd0, cin};
        // carry/borrow into each bit position
        cb = {1'b0, cur_reg} ^ {1'b0, s1_data_reg} ^ full;
    end

    always_comb
    begin
        cur_next    = cur_reg;
        shadow_next = shadow_reg;
        flags_next  = s1_flags_reg;
        case (s1_op_reg)
            OP_LOAD:  cur_next = s1_data_reg;
            OP_SETLO: cur_next = {cur_reg[15:8], s1_data_reg[7:0]};
            OP_SETHI: cur_next = {s1_data_reg[7:0], cur_reg[7:0]};
            OP_INCW:  cur_next = cur_reg + 16'd1;
            OP_DECW:  cur_next = cur_reg - 16'd1;
            OP_INCLO, OP_DECLO:
            begin
                cur_next   = {cur_reg[15:8], bs.value};
                flags_next = bs.flags;
            end
            OP_INCHI, OP_DECHI:
            begin
                cur_next   = {bs.value, cur_reg[7:0]};
                flags_next = bs.flags;
            end
            OP_ADD, OP_ADC, OP_SBC:
            begin
                cur_next = full[15:0];
                flags_next[FLAG_H] = cb[12];
                flags_next[FLAG_C] = cb[16];
                if (s1_op_reg != OP_ADD)
                begin
                    // signed overflow: carry into bit 15 differs from carry out
                    flags_next[FLAG_PV] = cb[16] ^ cb[15];
                    flags_next[FLAG_Z]  = (full[15:0] == 16'd0);
                    flags_next[FLAG_S]  = full[15];
                end
                flags_next[FLAG_N]  = (s1_op_reg == OP_SBC);
                flags_next[FLAG_B3] = full[8 + FLAG_B3];
                flags_next[FLAG_B5] = full[8 + FLAG_B5];
            end
            OP_SWAP:
            begin
                cur_next    = shadow_reg;
                shadow_next = cur_reg;
            end
            // unused codes leave state and flags alone
            default: cur_next = cur_reg;
        endcase
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= 16'd0;
            shadow_reg    <= 16'd0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= cur_next;
                shadow_reg    <= shadow_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_op_reg    <= opcode;
            s1_data_reg  <= data_word;
            s1_flags_reg <= flags_in;
        end
        if (s1_adv)
        begin
            out_value_reg <= cur_next;
            out_flags_reg <= flags_next;
        end
    end

    // a word leaving the input stage always lands in the result register
    a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced word missing from result register");

    // state only changes when a word advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> ($stable(cur_reg) && $stable(shadow_reg)))
        else $error("state changed without an advancing word");

    // swap moves the old current word into the shadow
    a_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_op_reg == OP_SWAP)) |=>
            (shadow_reg == $past(cur_reg)) && (cur_reg == $past(shadow_reg)))
        else $error("swap did not exchange the pair");

    // word inc/dec leaves flags untouched
    a_incw_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && ((s1_op_reg == OP_INCW) || (s1_op_reg == OP_DECW))) |=>
            (out_flags_reg == $past(s1_flags_reg)))
        else $error("word inc/dec altered flags");

    // the result register always mirrors the current word
    a_result_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (out_value_reg == cur_reg))
        else $error("result word differs from current word");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import rpa_pkg::*;

    // one input word as the sender sees it; hold_for_idle makes the sender
    // wait until every expected result word has come back before offering it
    typedef struct {
        logic [3:0]  op;
        logic [15:0] data;
        logic [7:0]  flags;
        bit          hold_for_idle;
    } cmd_word_t;

    // one expected result word
    typedef struct {
        logic [15:0] value;
        logic [7:0]  flags;
    } pair_result_t;

    localparam int NUM_RANDOM_WORDS = 550;
    localparam int IDLE_LIMIT       = 3000;   // cycles with no handshake on either side
    localparam int LONG_HOLD_CYCLES = 120;    // receiver hold-off that fills the block
    localparam int DRAIN_CYCLES     = 10;     // extra cycles after the last result word

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  opcode = '0;
    logic [15:0] data_word = '0;
    logic [7:0]  flags_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] reg_value;
    logic [7:0]  flags_out;

    cmd_word_t    cmd_q[$];       // words still to be offered
    pair_result_t result_q[$];    // results predicted but not yet seen

    // predictor copy of the register pair
    logic [15:0] pair_word;
    logic [15:0] pair_shadow;

    int words_in;
    int words_out;
    int err_count;
    int idle_cycles;

    register_pair_arith_with_flags_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .data_word (data_word),
        .flags_in  (flags_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .reg_value (reg_value),
        .flags_out (flags_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // 8-bit inc/dec of one byte: returns {new byte, new flags}
    // H is the nibble carry/borrow, PV marks the signed wrap, C/b3/b5 kept
    function automatic logic [15:0] bump_byte(input logic [7:0] b, input bit down,
                                              input logic [7:0] f);
        logic [7:0] r;
        logic [7:0] g;
        g = f;
        r = down ? (b - 8'd1) : (b + 8'd1);
        g[FLAG_H]  = down ? (r[3:0] == 4'hF) : (r[3:0] == 4'h0);
        g[FLAG_PV] = down ? (r == 8'h7F) : (r == 8'h80);
        g[FLAG_N]  = down;
        g[FLAG_Z]  = (r == 8'h00);
        g[FLAG_S]  = r[7];
        return {r, g};
    endfunction

    // 16-bit add / adc / sbc: returns {new word, new flags}
    // carries recovered from a ^ d ^ sum over 17 bits
    function automatic logic [23:0] word_arith(input logic [15:0] a, input logic [15:0] d,
                                               input logic [3:0] op, input logic [7:0] f);
        logic [16:0] full;
        logic [16:0] cb;
        logic [15:0] r;
        logic [7:0]  g;
        logic        cin;
        g   = f;
        cin = (op != OP_ADD) && f[FLAG_C];
        if (op == OP_SBC)
            full = {1'b0, a} - {1'b0, d} - {16'd0, cin};
        else
            full = {1'b0, a} + {1'b0, d} + {16'd0, cin};
        cb = {1'b0, a} ^ {1'b0, d} ^ full;
        r  = full[15:0];
        g[FLAG_H] = cb[12];
        g[FLAG_C] = cb[16];
        // plain add leaves S, Z and PV alone
        if (op != OP_ADD)
        begin
            g[FLAG_PV] = cb[16] ^ cb[15];
            g[FLAG_Z]  = (r == 16'h0000);
            g[FLAG_S]  = r[15];
        end
        g[FLAG_N]  = (op == OP_SBC);
        g[FLAG_B3] = r[11];
        g[FLAG_B5] = r[13];
        return {r, g};
    endfunction

    // apply one accepted word to the predictor state and queue its result
    function automatic void predict_pair(input logic [3:0] op, input logic [15:0] d,
                                         input logic [7:0] f);
        logic [15:0]  w;
        logic [15:0]  bs;
        logic [23:0]  ws;
        logic [7:0]   g;
        pair_result_t res;
        w = pair_word;
        g = f;
        case (op)
            OP_LOAD:  w = d;
            OP_SETLO: w = {pair_word[15:8], d[7:0]};
            OP_SETHI: w = {d[7:0], pair_word[7:0]};
            OP_INCW:  w = pair_word + 16'd1;
            OP_DECW:  w = pair_word - 16'd1;
            OP_INCLO, OP_DECLO:
            begin
                bs = bump_byte(pair_word[7:0], op == OP_DECLO, f);
                w  = {pair_word[15:8], bs[15:8]};
                g  = bs[7:0];
            end
            OP_INCHI, OP_DECHI:
            begin
                bs = bump_byte(pair_word[15:8], op == OP_DECHI, f);
                w  = {bs[15:8], pair_word[7:0]};
                g  = bs[7:0];
            end
            OP_ADD, OP_ADC, OP_SBC:
            begin
                ws = word_arith(pair_word, d, op, f);
                w  = ws[23:8];
                g  = ws[7:0];
            end
            OP_SWAP:
            begin
                w           = pair_shadow;
                pair_shadow = pair_word;
            end
            default: ;
        endcase
        pair_word = w;
        res.value = w;
        res.flags = g;
        result_q.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_cmd(input logic [3:0] op, input logic [15:0] d,
                                      input logic [7:0] f, input bit hold);
        cmd_word_t c;
        c.op            = op;
        c.data          = d;
        c.flags         = f;
        c.hold_for_idle = hold;
        cmd_q.push_back(c);
    endfunction

    // operand words lean toward the edges of the range
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0001;
            default: return 16'($urandom());
        endcase
    endfunction

    // sender gap after a word: mostly none, some short, a few long;
    // every fourth window of 40 words runs back to back
    function automatic int pick_gap();
        int r;
        if ((words_in / 40) % 4 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued words, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        int        gap_left;
        bit        took;
        cmd_word_t c;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= '0;
            data_word <= '0;
            flags_in  <= '0;
            gap_left  = 0;
            words_in  = 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                predict_pair(opcode, data_word, flags_in);
                words_in++;
                gap_left = pick_gap();
            end
            // a stalled word stays on the port untouched
            if (!in_valid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() > 0 &&
                         (!cmd_q[0].hold_for_idle || result_q.size() == 0))
                begin
                    c = cmd_q.pop_front();
                    in_valid  <= 1'b1;
                    opcode    <= c.op;
                    data_word <= c.data;
                    flags_in  <= c.flags;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : stall_proc
        int hold_left;
        bit long_done;
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            long_done = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!long_done && words_out >= 150)
        begin
            // long hold-off while the sender keeps offering, so the block backs up
            long_done = 1;
            hold_left = LONG_HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if ((words_out / 50) % 4 == 2)
            out_stall <= 1'b0;          // stretch with no stalls at all
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                hold_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(5, 25);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each result word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        pair_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_out++;
            if (result_q.size() == 0)
            begin
                $error("result word with no prediction: reg_value %h flags_out %h",
                       reg_value, flags_out);
                err_count++;
            end
            else
            begin
                want = result_q.pop_front();
                if (reg_value !== want.value)
                begin
                    $error("reg_value mismatch: expected %h, actual %h", want.value, reg_value);
                    err_count++;
                end
                if (flags_out !== want.flags)
                begin
                    $error("flags_out mismatch: expected %h, actual %h", want.flags, flags_out);
                    err_count++;
                end
            end
        end
    end

    // watchdog: ends the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stim_proc
        logic [3:0] op;
        err_count   = 0;
        words_out   = 0;
        idle_cycles = 0;
        pair_word   = '0;
        pair_shadow = '0;

        // directed: wraps, byte overflow corners, carries, zero and overflow
        queue_cmd(OP_LOAD,  16'h0000, 8'h00, 0);
        queue_cmd(OP_DECW,  16'h0000, 8'hFF, 0);   // word wraps down to ffff
        queue_cmd(OP_INCW,  16'hFFFF, 8'h00, 0);   // and back up to zero
        queue_cmd(OP_LOAD,  16'hFFFF, 8'h00, 0);
        queue_cmd(OP_SETLO, 16'h127F, 8'h00, 0);   // only the low byte lands
        queue_cmd(OP_INCLO, 16'h0000, 8'h00, 0);   // 7f -> 80: overflow, sign, half carry
        queue_cmd(OP_DECLO, 16'h0000, 8'hFF, 0);   // 80 -> 7f: overflow, half borrow
        queue_cmd(OP_SETHI, 16'hFF00, 8'h00, 0);
        queue_cmd(OP_DECHI, 16'h0000, 8'h00, 0);   // 00 -> ff borrow
        queue_cmd(OP_INCHI, 16'h0000, 8'hFF, 0);   // ff -> 00 zero
        queue_cmd(OP_LOAD,  16'h8FFF, 8'h00, 0);
        queue_cmd(OP_ADD,   16'h7001, 8'h00, 0);   // carry out of bits 11 and 15
        queue_cmd(OP_LOAD,  16'hFFFF, 8'h00, 0);
        queue_cmd(OP_ADC,   16'h0000, 8'h01, 0);   // carry in wraps to zero
        queue_cmd(OP_LOAD,  16'h7FFF, 8'h00, 0);
        queue_cmd(OP_ADC,   16'h0000, 8'h01, 0);   // signed overflow to 8000
        queue_cmd(OP_LOAD,  16'h0000, 8'h00, 0);
        queue_cmd(OP_SBC,   16'h0000, 8'h01, 0);   // borrow in wraps to ffff
        queue_cmd(OP_LOAD,  16'h8000, 8'h00, 0);
        queue_cmd(OP_SBC,   16'h0001, 8'hFE, 0);   // signed overflow to 7fff
        queue_cmd(OP_SWAP,  16'hFFFF, 8'h00, 0);
        queue_cmd(OP_LOAD,  16'hA5A5, 8'h5A, 1);   // sender waits for the block to drain
        queue_cmd(OP_SWAP,  16'h0000, 8'hFF, 0);
        queue_cmd(OP_ADD,   16'hFFFF, 8'hFF, 0);
        queue_cmd(OP_SWAP,  16'h0000, 8'h00, 0);

        // random words; loads are weighted up so arithmetic sees fresh operands
        for (int i = 0; i < NUM_RANDOM_WORDS; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                op = OP_LOAD;
            else
                op = 4'($urandom_range(OP_LOAD, OP_SWAP));
            queue_cmd(op, pick_operand(), 8'($urandom_range(0, 255)),
                      (i == 200) || (i == 400));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() > 0 || in_valid)
            @(posedge clk);
        while (result_q.size() > 0)
            @(posedge clk);
        // let any stray result word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && result_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
